FILE: hdl/regression_loss_gradient_unit_defines.svh
// assertion macros for the regression loss and gradient unit checker
// depends on a clk and a rst signal in the scope where a macro is used
`ifndef REGRESSION_LOSS_GRADIENT_UNIT_DEFINES_SVH
`define REGRESSION_LOSS_GRADIENT_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define RLG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlg assertion failed");

// next-cycle implication, off during reset
`define RLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlg assertion failed");

// next-cycle implication that also holds across reset
`define RLG_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rlg assertion failed");

`endif

FILE: hdl/rlg_pkg.sv
// shared types, widths and codes of the regression loss and gradient unit
// no dependencies
`timescale 1ns / 1ps

package rlg_pkg;

  localparam int DATA_W   = 16;
  localparam int DIFF_W   = 17;
  localparam int GRAD_W   = 18;
  localparam int MEAN_W   = 35;
  localparam int ACC_W    = 47;
  localparam int MODE_W   = 2;
  localparam int DELTA_W  = 17;
  localparam int RECIP_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int MUL_A_W  = 24;
  localparam int MUL_B_W  = 18;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // loss modes
  localparam logic [MODE_W-1:0] MODE_MSE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L1    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HUBER = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUBER_DELTA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_COUNT = 2'd2;

  // reset values
  localparam logic [MODE_W-1:0]  RST_LOSS_MODE   = MODE_MSE;
  localparam logic [DELTA_W-1:0] RST_HUBER_DELTA = 17'd4096;
  localparam logic [RECIP_W-1:0] RST_RECIP_COUNT = 17'd65536;

  typedef struct packed {
    logic [MODE_W-1:0]  loss_mode;
    logic [DELTA_W-1:0] huber_delta;
    logic [RECIP_W-1:0] reciprocal_count;
  } cfg_t;

endpackage

FILE: hdl/rlg_if.sv
// channel interfaces: input pairs, results and register writes
// depends on rlg_pkg
`timescale 1ns / 1ps

interface rlg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rlg_pkg::DATA_W-1:0]    predicted;
  logic signed [rlg_pkg::DATA_W-1:0]    target_value;
  logic                                 is_last;

  modport source (output valid, predicted, target_value, is_last, input ready);
  modport sink   (input valid, predicted, target_value, is_last, output ready);
endinterface

interface rlg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rlg_pkg::GRAD_W-1:0]    gradient;
  logic        [rlg_pkg::MEAN_W-1:0]    mean_loss;
  logic                                 loss_valid;

  modport source (output valid, gradient, mean_loss, loss_valid, input ready);
  modport sink   (input valid, gradient, mean_loss, loss_valid, output ready);
endinterface

interface rlg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rlg_pkg::CFG_IDX_W-1:0]      index;
  logic [rlg_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rlg_cfg_regs.sv
// configuration registers: loss mode, huber threshold, reciprocal count
// depends on rlg_pkg and rlg_cfg_if
`timescale 1ns / 1ps

module rlg_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  rlg_cfg_if.sink         cfg,
  output rlg_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.loss_mode        <= rlg_pkg::RST_LOSS_MODE;
      regs.huber_delta      <= rlg_pkg::RST_HUBER_DELTA;
      regs.reciprocal_count <= rlg_pkg::RST_RECIP_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        rlg_pkg::REG_LOSS_MODE:   regs.loss_mode <= cfg.data[rlg_pkg::MODE_W-1:0];
        rlg_pkg::REG_HUBER_DELTA: regs.huber_delta <= cfg.data[rlg_pkg::DELTA_W-1:0];
        rlg_pkg::REG_RECIP_COUNT: regs.reciprocal_count <= cfg.data[rlg_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/rlg_mul.sv
// shared unsigned multiplier with a registered product
// depends on rlg_pkg
`timescale 1ns / 1ps

module rlg_mul (
  input  logic                           clk,
  input  logic [rlg_pkg::MUL_A_W-1:0]    a,
  input  logic [rlg_pkg::MUL_B_W-1:0]    b,
  output logic [rlg_pkg::MUL_P_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= rlg_pkg::MUL_P_W'(a) * rlg_pkg::MUL_P_W'(b);
  end

endmodule

FILE: hdl/regression_loss_gradient_unit.sv
// regression loss and gradient unit (mse, l1, huber) around one shared multiplier
// depends on rlg_pkg, rlg_if, rlg_cfg_regs and rlg_mul
// steps: loss term, gradient, magnitude, and on a last element mean low, high and sum;
// a new element is taken only in the idle state; the shared multiplier
//   is used for the loss term, the gradient and two halves of the mean product
// reset: synchronous, clears sequencer, accumulator, output valid and registers
`timescale 1ns / 1ps

module regression_loss_gradient_unit (
  input  logic     clk,
  input  logic     rst,
  rlg_cfg_if.sink  cfg,
  rlg_in_if.sink   samples,
  rlg_out_if.source results
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TERM = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_GMAG = 3'd3;
  localparam logic [2:0] S_MLO  = 3'd4;
  localparam logic [2:0] S_MHI  = 3'd5;
  localparam logic [2:0] S_MSUM = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int GMAG_W = rlg_pkg::MUL_P_W - 15;
  localparam int PLO_W  = rlg_pkg::MUL_P_W - 16;
  localparam int MSUM_W = 49;
  localparam logic [GMAG_W-1:0] GMAG_POS_MAX = GMAG_W'(131071);
  localparam logic [GMAG_W-1:0] GMAG_NEG_MAX = GMAG_W'(131072);

  rlg_pkg::cfg_t regs;

  logic [2:0]                        state;
  logic [rlg_pkg::DIFF_W-1:0]        ad;
  logic                              neg;
  logic                              last;
  logic [rlg_pkg::ACC_W-1:0]         acc;
  logic [PLO_W-1:0]                  plo;
  logic [rlg_pkg::GRAD_W-1:0]        grad_q;
  logic [rlg_pkg::MEAN_W-1:0]        mean_q;
  logic                              out_valid;
  logic [rlg_pkg::GRAD_W-1:0]        out_grad;
  logic [rlg_pkg::MEAN_W-1:0]        out_mean;
  logic                              out_last;

  logic [rlg_pkg::MUL_A_W-1:0]       mul_a;
  logic [rlg_pkg::MUL_B_W-1:0]       mul_b;
  logic [rlg_pkg::MUL_P_W-1:0]       prod;

  logic signed [rlg_pkg::DIFF_W-1:0] diff;
  logic                              is_l1;
  logic                              is_huber;
  logic                              huber_in;
  logic [rlg_pkg::MUL_B_W-1:0]       twice_ad_m_dl;
  logic [rlg_pkg::MUL_P_W-1:0]       term;
  logic [rlg_pkg::ACC_W:0]           acc_sum;
  logic [GMAG_W-1:0]                 gmag;
  logic [rlg_pkg::GRAD_W-1:0]        grad_sat;
  logic [MSUM_W-1:0]                 msum;
  logic                              out_free;

  rlg_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rlg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign diff = {samples.predicted[rlg_pkg::DATA_W-1], samples.predicted}
              - {samples.target_value[rlg_pkg::DATA_W-1], samples.target_value};

  // mode 3 falls through to mse
  assign is_l1    = (regs.loss_mode == rlg_pkg::MODE_L1);
  assign is_huber = (regs.loss_mode == rlg_pkg::MODE_HUBER);
  assign huber_in = (ad <= regs.huber_delta);
  assign twice_ad_m_dl = {ad, 1'b0} - {1'b0, regs.huber_delta};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TERM: begin
        if (is_huber && !huber_in) begin
          mul_a = rlg_pkg::MUL_A_W'(regs.huber_delta);
          mul_b = twice_ad_m_dl;
        end else begin
          mul_a = rlg_pkg::MUL_A_W'(ad);
          mul_b = rlg_pkg::MUL_B_W'(ad);
        end
      end
      S_GRAD: begin
        mul_a = (is_huber && !huber_in) ? rlg_pkg::MUL_A_W'(regs.huber_delta)
                                        : rlg_pkg::MUL_A_W'(ad);
        mul_b = rlg_pkg::MUL_B_W'(regs.reciprocal_count);
      end
      S_MLO: begin
        mul_a = acc[rlg_pkg::MUL_A_W-1:0];
        mul_b = rlg_pkg::MUL_B_W'(regs.reciprocal_count);
      end
      S_MHI: begin
        mul_a = rlg_pkg::MUL_A_W'(acc[rlg_pkg::ACC_W-1:rlg_pkg::MUL_A_W]);
        mul_b = rlg_pkg::MUL_B_W'(regs.reciprocal_count);
      end
      default: ;
    endcase
  end

  // loss term: l1 from the magnitude, else the product of the term step, huber halves truncated
  always_comb begin
    if (is_l1) begin
      term = rlg_pkg::MUL_P_W'({ad, 12'b0});
    end else if (is_huber) begin
      term = {1'b0, prod[rlg_pkg::MUL_P_W-1:1]};
    end else begin
      term = prod;
    end
  end

  assign acc_sum = {1'b0, acc} + (rlg_pkg::ACC_W + 1)'(term);

  // gradient magnitude: mse doubles, so it shifts one place less
  always_comb begin
    if (is_l1) begin
      gmag = (ad != '0) ? GMAG_W'(regs.reciprocal_count[rlg_pkg::RECIP_W-1:4]) : '0;
    end else if (is_huber) begin
      gmag = GMAG_W'(prod[rlg_pkg::MUL_P_W-1:16]);
    end else begin
      gmag = prod[rlg_pkg::MUL_P_W-1:15];
    end
  end

  always_comb begin
    if (neg) begin
      grad_sat = (gmag > GMAG_NEG_MAX) ? {1'b1, {(rlg_pkg::GRAD_W-1){1'b0}}}
                                       : -gmag[rlg_pkg::GRAD_W-1:0];
    end else begin
      grad_sat = (gmag > GMAG_POS_MAX) ? {1'b0, {(rlg_pkg::GRAD_W-1){1'b1}}}
                                       : gmag[rlg_pkg::GRAD_W-1:0];
    end
  end

  // low partial is already down 16, so the high partial lands 8 bits up
  assign msum = {prod[40:0], 8'b0} + MSUM_W'(plo);

  assign out_free = !out_valid || results.ready;

  assign samples.ready      = (state == S_IDLE);
  assign results.valid      = out_valid;
  assign results.gradient   = out_grad;
  assign results.mean_loss  = out_mean;
  assign results.loss_valid = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            state <= S_TERM;
          end
        end
        S_TERM: state <= S_GRAD;
        S_GRAD: begin
          acc   <= acc_sum[rlg_pkg::ACC_W] ? {rlg_pkg::ACC_W{1'b1}}
                                           : acc_sum[rlg_pkg::ACC_W-1:0];
          state <= S_GMAG;
        end
        S_GMAG: state <= last ? S_MLO : S_DONE;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_MSUM;
        S_MSUM: begin
          acc   <= '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && samples.valid) begin
      neg  <= diff[rlg_pkg::DIFF_W-1];
      ad   <= diff[rlg_pkg::DIFF_W-1] ? rlg_pkg::DIFF_W'(-diff) : rlg_pkg::DIFF_W'(diff);
      last <= samples.is_last;
    end
    if (state == S_GMAG) begin
      grad_q <= grad_sat;
      mean_q <= '0;
    end
    if (state == S_MHI) begin
      plo <= prod[rlg_pkg::MUL_P_W-1:16];
    end
    if (state == S_MSUM) begin
      mean_q <= (msum[MSUM_W-1:rlg_pkg::MEAN_W] != '0) ? {rlg_pkg::MEAN_W{1'b1}}
                                                       : msum[rlg_pkg::MEAN_W-1:0];
    end
    if (state == S_DONE && out_free) begin
      out_grad <= grad_q;
      out_mean <= mean_q;
      out_last <= last;
    end
  end

endmodule

FILE: hdl/rlg_checker.sv
// port-level checker for regression_loss_gradient_unit, bound to the top level
// depends on rlg_pkg and regression_loss_gradient_unit_defines.svh
`timescale 1ns / 1ps
`include "regression_loss_gradient_unit_defines.svh"

module rlg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [rlg_pkg::GRAD_W-1:0]     out_gradient,
  input logic [rlg_pkg::MEAN_W-1:0]     out_mean_loss,
  input logic                           out_loss_valid
);

  // no result survives reset
  `RLG_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)

  // one element at a time: after an input beat the block is busy
  `RLG_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)

  // a non-final beat carries no mean
  `RLG_ASSERT_IMPL(a_mean_only_last, out_valid && !out_loss_valid, out_mean_loss == '0)

  // a stalled result holds
  `RLG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_gradient) && $stable(out_mean_loss)
                   && $stable(out_loss_valid))

endmodule

bind regression_loss_gradient_unit rlg_checker u_rlg_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_gradient   (results.gradient),
  .out_mean_loss  (results.mean_loss),
  .out_loss_valid (results.loss_valid)
);

FILE: bench/tb_regression_loss_gradient_unit.sv
// self-checking bench for the regression loss and gradient unit: mse, l1 and huber
// losses and gradients checked beat by beat against an in-bench loss predictor
// depends on rlg_pkg, rlg_if and regression_loss_gradient_unit
`timescale 1ns / 1ps

module tb_regression_loss_gradient_unit;

  localparam int          STALL_LIMIT = 4000;
  localparam int          SETTLE_CYCLES = 16;
  localparam logic [63:0] ACC_CEIL = (64'd1 << rlg_pkg::ACC_W) - 64'd1;
  localparam logic [63:0] MEAN_CEIL = (64'd1 << rlg_pkg::MEAN_W) - 64'd1;
  localparam logic [63:0] GRAD_POS_CEIL = 64'd131071;
  localparam logic [63:0] GRAD_NEG_CEIL = 64'd131072;
  localparam int          DATA_MIN = -32768;
  localparam int          DATA_MAX = 32767;

  typedef struct packed {
    logic signed [rlg_pkg::DATA_W-1:0] predicted;
    logic signed [rlg_pkg::DATA_W-1:0] target_value;
    logic                              is_last;
  } sample_t;

  typedef struct packed {
    logic signed [rlg_pkg::GRAD_W-1:0] gradient;
    logic [rlg_pkg::MEAN_W-1:0]        mean_loss;
    logic                              loss_valid;
  } loss_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rlg_cfg_if cfg_bus ();
  rlg_in_if  in_bus ();
  rlg_out_if out_bus ();

  regression_loss_gradient_unit uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (in_bus),
    .results (out_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor copy of the block's registers and accumulator
  logic [rlg_pkg::MODE_W-1:0] pred_mode;
  logic [63:0]                pred_delta;
  logic [63:0]                pred_recip;
  logic [63:0]                pred_acc;

  sample_t      pending_samples[$];
  loss_result_t expected_results[$];
  sample_t      next_beat;
  loss_result_t seen;
  loss_result_t want;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           fail_count = 0;
  int           stall_cycles = 0;

  function automatic loss_result_t predict_loss(logic signed [rlg_pkg::DATA_W-1:0] p,
                                                logic signed [rlg_pkg::DATA_W-1:0] t,
                                                logic last);
    int           diff;
    logic         neg;
    logic [63:0]  mag;
    logic [63:0]  term;
    logic [63:0]  gmag;
    logic [63:0]  avg;
    loss_result_t r;
    diff = int'(p) - int'(t);
    neg = diff < 0;
    mag = neg ? 64'(-diff) : 64'(diff);
    case (pred_mode)
      rlg_pkg::MODE_L1: begin
        term = mag << 12;
        gmag = (mag != 0) ? (pred_recip >> 4) : 64'd0;
      end
      rlg_pkg::MODE_HUBER: begin
        if (mag <= pred_delta) begin
          term = (mag * mag) >> 1;
          gmag = (mag * pred_recip) >> 16;
        end else begin
          term = (pred_delta * (2 * mag - pred_delta)) >> 1;
          gmag = (pred_delta * pred_recip) >> 16;
        end
      end
      // mse, and the unused code behaves the same
      default: begin
        term = mag * mag;
        gmag = (2 * mag * pred_recip) >> 16;
      end
    endcase
    pred_acc = pred_acc + term;
    if (pred_acc > ACC_CEIL) pred_acc = ACC_CEIL;
    if (neg) begin
      r.gradient = (gmag >= GRAD_NEG_CEIL) ? -rlg_pkg::GRAD_W'(GRAD_NEG_CEIL)
                                           : -rlg_pkg::GRAD_W'(gmag);
    end else begin
      r.gradient = (gmag > GRAD_POS_CEIL) ? rlg_pkg::GRAD_W'(GRAD_POS_CEIL)
                                          : rlg_pkg::GRAD_W'(gmag);
    end
    if (last) begin
      avg = (pred_acc * pred_recip) >> 16;
      if (avg > MEAN_CEIL) avg = MEAN_CEIL;
      r.mean_loss = rlg_pkg::MEAN_W'(avg);
      r.loss_valid = 1'b1;
      pred_acc = 64'd0;
    end else begin
      r.mean_loss = '0;
      r.loss_valid = 1'b0;
    end
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(predict_loss(in_bus.predicted, in_bus.target_value,
                                                in_bus.is_last));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_samples.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.predicted    <= next_beat.predicted;
          in_bus.target_value <= next_beat.target_value;
          in_bus.is_last      <= next_beat.is_last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen = '{out_bus.gradient, out_bus.mean_loss, out_bus.loss_valid};
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: gradient %0d mean_loss %0d",
                 seen.gradient, seen.mean_loss);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (seen.gradient !== want.gradient) begin
            $error("gradient: expected %0d, got %0d", want.gradient, seen.gradient);
            fail_count++;
          end
          if (seen.mean_loss !== want.mean_loss) begin
            $error("mean_loss: expected %0d, got %0d", want.mean_loss, seen.mean_loss);
            fail_count++;
          end
          if (seen.loss_valid !== want.loss_valid) begin
            $error("loss_valid: expected %0d, got %0d", want.loss_valid, seen.loss_valid);
            fail_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(logic [rlg_pkg::CFG_IDX_W-1:0] idx,
                           logic [rlg_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      rlg_pkg::REG_LOSS_MODE:   pred_mode = value[rlg_pkg::MODE_W-1:0];
      rlg_pkg::REG_HUBER_DELTA: pred_delta = 64'(value);
      rlg_pkg::REG_RECIP_COUNT: pred_recip = 64'(value);
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_loss(logic [rlg_pkg::MODE_W-1:0] mode, int delta, int recip);
    write_reg(rlg_pkg::REG_LOSS_MODE, rlg_pkg::CFG_DATA_W'(mode));
    write_reg(rlg_pkg::REG_HUBER_DELTA, rlg_pkg::CFG_DATA_W'(delta));
    write_reg(rlg_pkg::REG_RECIP_COUNT, rlg_pkg::CFG_DATA_W'(recip));
  endtask

  task automatic push_sample(int p, int t, bit last);
    pending_samples.push_back('{rlg_pkg::DATA_W'(p), rlg_pkg::DATA_W'(t), last});
  endtask

  // waits until every queued sample is sent and every expected beat has come back
  task automatic drain();
    while (pending_samples.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic int pick_target(int p, int delta);
    int span;
    int t;
    case ($urandom_range(5))
      0: t = int'($signed(rlg_pkg::DATA_W'($urandom)));
      1: t = p;
      2: t = $urandom_range(1) ? DATA_MIN : DATA_MAX;
      default: begin
        // land near the huber threshold or inside it
        span = (delta > 0 && delta < 20000) ? delta + 16 : 4096;
        t = p + int'($urandom_range(2 * span)) - span;
      end
    endcase
    if (t < DATA_MIN) t = DATA_MIN;
    if (t > DATA_MAX) t = DATA_MAX;
    return t;
  endfunction

  task automatic random_setting(int quota);
    logic [rlg_pkg::MODE_W-1:0] mode;
    int delta;
    int recip;
    int count;
    int len;
    int p;
    mode = rlg_pkg::MODE_W'($urandom_range(3));
    case ($urandom_range(4))
      0: delta = 0;
      1: delta = 131071;
      2, 3: delta = $urandom_range(16384);
      default: delta = $urandom_range(131071);
    endcase
    case ($urandom_range(6))
      0: recip = 0;
      1: recip = 131071;
      2: recip = 1;
      default: recip = $urandom_range(65536, 1);
    endcase
    set_loss(mode, delta, recip);
    count = 0;
    while (count < quota) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        p = int'($signed(rlg_pkg::DATA_W'($urandom)));
        push_sample(p, pick_target(p, delta), i == len - 1);
      end
      count += len;
    end
    drain();
  endtask

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    pred_mode  = rlg_pkg::RST_LOSS_MODE;
    pred_delta = 64'(rlg_pkg::RST_HUBER_DELTA);
    pred_recip = 64'(rlg_pkg::RST_RECIP_COUNT);
    pred_acc   = 64'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 37;
    recv_idle_pct = 87;

    // reset settings: mse, full-scale differences of both signs
    push_sample(DATA_MAX, DATA_MIN, 1'b0);
    push_sample(DATA_MIN, DATA_MAX, 1'b0);
    push_sample(0, 0, 1'b0);
    push_sample(-1, 0, 1'b1);
    drain();
    write_reg(rlg_pkg::REG_LOSS_MODE, rlg_pkg::CFG_DATA_W'(rlg_pkg::MODE_L1));
    push_sample(100, -100, 1'b0);
    push_sample(-7, 3, 1'b0);
    push_sample(0, 0, 1'b1);
    drain();
    // huber at, just below and well beyond the threshold
    set_loss(rlg_pkg::MODE_HUBER, 4096, 65536);
    push_sample(4096, 0, 1'b0);
    push_sample(4095, 0, 1'b0);
    push_sample(DATA_MIN, DATA_MAX, 1'b0);
    push_sample(3, 0, 1'b1);
    drain();
    write_reg(rlg_pkg::REG_HUBER_DELTA, '0);
    push_sample(0, 0, 1'b0);
    push_sample(1, 0, 1'b0);
    push_sample(-1, 0, 1'b1);
    drain();
    // oversized reciprocal: near full-scale gradients of both signs
    set_loss(rlg_pkg::MODE_HUBER, 131071, 131071);
    push_sample(DATA_MAX, DATA_MIN, 1'b0);
    push_sample(DATA_MIN, DATA_MAX, 1'b1);
    drain();
    // unused mode code with a zero reciprocal
    set_loss(rlg_pkg::MODE_W'(3), 4096, 0);
    push_sample(1234, -20000, 1'b0);
    push_sample(DATA_MIN, DATA_MAX, 1'b1);
    drain();
    set_loss(rlg_pkg::MODE_MSE, 4096, 131071);
    push_sample(DATA_MAX, DATA_MIN, 1'b0);
    push_sample(DATA_MAX, DATA_MIN, 1'b0);
    push_sample(DATA_MIN, DATA_MAX, 1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 5; s++) random_setting(60);
    end

    // long full-scale vector with an oversized reciprocal clips the mean
    set_loss(rlg_pkg::MODE_MSE, 4096, 131071);
    for (int i = 0; i < 48; i++) push_sample(DATA_MAX, DATA_MIN, 1'b0);
    push_sample(DATA_MIN, DATA_MAX, 1'b1);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
